[sv/mvnf_pkg.sv]
// ----------------------------------------------------------------------------
// mvnf_pkg
// Shared constants and types of the match value neighbourhood fill unit.
// ----------------------------------------------------------------------------
package mvnf_pkg;

	// default frame limits
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	// field and port widths
	localparam int PIXEL_W     = 8;
	localparam int CFG_DATA_W  = 11;
	localparam int CFG_INDEX_W = 2;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_VALUE  = 2'd2;

	// register reset values
	localparam int                 RST_IMAGE_DIM   = 1024;
	localparam logic [PIXEL_W-1:0] RST_MATCH_VALUE = 8'd0;

	// request kinds
	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_FLUSH = 1'b1;

	// one column of the line buffer: pixel of the row above, flags of the two rows above
	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic               flag_prev;
		logic               flag_prev2;
	} line_word_t;

	localparam int LINE_WORD_W = $bits(line_word_t);

endpackage

[sv/match_value_neighborhood_fill_unit.sv]
// A completing transfer is held in stage 1; its result is then registered in the output register.
// Throughput: one item per cycle unless output stalls; buffer read per item, written per pixel.
// A frame of height one takes one extra internal tick after its last pixel.
// Reset clears control state only; the line buffer holds no valid bits and needs no clearing.
// ----------------------------------------------------------------------------
// match_value_neighborhood_fill_unit
// 3x3 dilation of the match mask of a raster-order 8-bit frame. A single line
// buffer holds, per column, the pixel of the previous row and the match flags
// of the two previous rows; a vertical OR per column feeds a three-wide
// horizontal window that selects the fill value or the delayed pixel.
// ----------------------------------------------------------------------------
module match_value_neighborhood_fill_unit #(
	parameter int MAX_WIDTH  = mvnf_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = mvnf_pkg::DEF_MAX_HEIGHT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// input channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               req_type,
	input  logic [mvnf_pkg::PIXEL_W-1:0]       pixel_in,
	// output channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [mvnf_pkg::PIXEL_W-1:0]       pixel_out,
	output logic                               frame_end,
	// configuration
	input  logic                               cfg_we,
	input  logic [mvnf_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [mvnf_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WID_W = $clog2(MAX_WIDTH + 1);
	localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
	localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
	localparam int RST_W = (mvnf_pkg::RST_IMAGE_DIM > MAX_WIDTH) ?
		MAX_WIDTH : mvnf_pkg::RST_IMAGE_DIM;
	localparam int RST_H = (mvnf_pkg::RST_IMAGE_DIM > MAX_HEIGHT) ?
		MAX_HEIGHT : mvnf_pkg::RST_IMAGE_DIM;

	// control carried with a tick into stage 1
	typedef struct packed {
		logic                         is_pixel;
		logic                         flag;
		logic [mvnf_pkg::PIXEL_W-1:0] pixel;
		logic [COL_W-1:0]             col;
		logic                         row_m1_ok;
		logic                         row_m2_ok;
		logic                         use_new;
		logic                         use_v2;
		logic                         emit;
		logic                         last;
	} tick_t;

	// configuration registers
	logic [WID_W-1:0]             width_q;
	logic [HGT_W-1:0]             height_q;
	logic [mvnf_pkg::PIXEL_W-1:0] match_q;
	logic [WID_W-1:0]             width_nxt;
	logic [HGT_W-1:0]             height_nxt;
	logic                         restart;

	// frame position of the next tick
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             done_q;

	// issue stage
	logic             auto_tick;
	logic             in_acc;
	logic             tick;
	logic             tick_pixel;
	logic [ROW_W-1:0] h_ext;
	logic             col_last;
	logic             final_tick;
	tick_t            tick_d;

	// stage 1
	logic                         tick_valid_s1;
	tick_t                        tick_s1;
	logic                         fwd_sel_s1;
	logic                         s1_adv;
	logic                         s1_fire;
	mvnf_pkg::line_word_t         ram_rdata;
	mvnf_pkg::line_word_t         rd_word;
	mvnf_pkg::line_word_t         wr_word;
	mvnf_pkg::line_word_t         fwd_word_q;
	logic                         ram_we;
	logic                         vnew;
	logic                         hit;
	logic                         vcol1_q;
	logic                         vcol2_q;
	logic [mvnf_pkg::PIXEL_W-1:0] pix1_q;

	// output register
	logic                         out_valid_q;
	logic [mvnf_pkg::PIXEL_W-1:0] pixel_out_q;
	logic                         frame_end_q;

	// dimension writes saturate to the supported range
	always_comb begin
		if (cfg_data == '0) begin
			width_nxt  = WID_W'(1);
			height_nxt = HGT_W'(1);
		end else begin
			width_nxt  = (32'(cfg_data) > 32'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : WID_W'(cfg_data);
			height_nxt = (32'(cfg_data) > 32'(MAX_HEIGHT)) ?
				HGT_W'(MAX_HEIGHT) : HGT_W'(cfg_data);
		end
	end

	assign restart = cfg_we &&
		(cfg_index == mvnf_pkg::CFG_IMAGE_WIDTH || cfg_index == mvnf_pkg::CFG_IMAGE_HEIGHT);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WID_W'(RST_W);
			height_q <= HGT_W'(RST_H);
			match_q  <= mvnf_pkg::RST_MATCH_VALUE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mvnf_pkg::CFG_IMAGE_WIDTH:  width_q  <= width_nxt;
				mvnf_pkg::CFG_IMAGE_HEIGHT: height_q <= height_nxt;
				mvnf_pkg::CFG_MATCH_VALUE:  match_q  <= cfg_data[mvnf_pkg::PIXEL_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1 moves on unless its result finds the output register blocked
	assign s1_adv  = !tick_valid_s1 || !tick_s1.emit || !out_valid_q || !out_stall;
	assign s1_fire = tick_valid_s1 && s1_adv;

	// height one: the drain needs one tick with no result, taken internally
	assign auto_tick = done_q && (row_q == ROW_W'(1)) && (col_q == '0);
	assign in_stall  = !s1_adv || auto_tick;
	assign in_acc    = in_valid && !in_stall;

	// early flushes are dropped; once the frame is in, every transfer drains
	assign tick_pixel = in_acc && !done_q && (req_type == mvnf_pkg::REQ_PIXEL);
	assign tick       = (in_acc && (done_q || req_type == mvnf_pkg::REQ_PIXEL)) ||
		(auto_tick && s1_adv);

	assign h_ext      = ROW_W'(height_q);
	assign col_last   = (WID_W'(col_q) == width_q - WID_W'(1));
	assign final_tick = done_q && (row_q == h_ext + ROW_W'(1));

	// tick classification: the tick at (row, col) completes output (row-1, col-1),
	// or (row-2, width-1) at the start of a row
	always_comb begin
		tick_d.is_pixel  = tick_pixel;
		tick_d.flag      = (pixel_in == match_q);
		tick_d.pixel     = pixel_in;
		tick_d.col       = col_q;
		tick_d.row_m1_ok = (row_q != '0) && (row_q <= h_ext);
		tick_d.row_m2_ok = (row_q >= ROW_W'(2)) && (row_q <= h_ext + ROW_W'(1));
		tick_d.use_new   = (col_q != '0);
		tick_d.use_v2    = (col_q != '0) ? (col_q >= COL_W'(2)) : (width_q >= WID_W'(2));
		tick_d.emit      = (row_q >= ROW_W'(2)) || ((row_q == ROW_W'(1)) && (col_q != '0));
		tick_d.last      = final_tick;
	end

	// frame position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			done_q <= 1'b0;
		end else if (restart) begin
			col_q  <= '0;
			row_q  <= '0;
			done_q <= 1'b0;
		end else if (tick) begin
			if (final_tick) begin
				col_q  <= '0;
				row_q  <= '0;
				done_q <= 1'b0;
			end else if (col_last) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
				if (!done_q && row_q == h_ext - ROW_W'(1)) begin
					done_q <= 1'b1;
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// stage 1 occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_valid_s1 <= 1'b0;
		end else if (tick) begin
			tick_valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			tick_valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload; forward when the read meets the write-back of the same column
	always_ff @(posedge clk) begin
		if (tick) begin
			tick_s1    <= tick_d;
			fwd_sel_s1 <= ram_we && (tick_s1.col == col_q);
		end
		if (ram_we) begin
			fwd_word_q <= wr_word;
		end
	end

	// line buffer, read at issue and written back from stage 1
	assign ram_we  = s1_fire && tick_s1.is_pixel;
	assign rd_word = fwd_sel_s1 ? fwd_word_q : ram_rdata;

	always_comb begin
		wr_word.pixel      = tick_s1.pixel;
		wr_word.flag_prev  = tick_s1.flag;
		wr_word.flag_prev2 = rd_word.flag_prev;
	end

	mvnf_ram #(
		.WIDTH (mvnf_pkg::LINE_WORD_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tick_s1.col),
		.wdata (wr_word),
		.re    (tick),
		.raddr (col_q),
		.rdata (ram_rdata)
	);

	// vertical OR of the column, then the horizontal window
	assign vnew = (tick_s1.is_pixel && tick_s1.flag) ||
		(rd_word.flag_prev && tick_s1.row_m1_ok) ||
		(rd_word.flag_prev2 && tick_s1.row_m2_ok);
	assign hit  = vcol1_q || (tick_s1.use_new && vnew) || (tick_s1.use_v2 && vcol2_q);

	// window shift register and delayed pixel
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			vcol2_q <= vcol1_q;
			vcol1_q <= vnew;
			pix1_q  <= rd_word.pixel;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && tick_s1.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && tick_s1.emit) begin
			pixel_out_q <= hit ? match_q : pix1_q;
			frame_end_q <= tick_s1.last;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pixel_out_q;
	assign frame_end = frame_end_q;

endmodule

[sv/mvnf_ram.sv]
// ----------------------------------------------------------------------------
// mvnf_ram
// Generic single write port, single read port RAM with registered read data.
// A read and a write to the same address in one cycle return the old word.
// ----------------------------------------------------------------------------
module mvnf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
